### sv/i2p_pkg.sv
// Shared types, character constants and decode functions for the infix to postfix converter.
`default_nettype none

package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STACK_DEPTH);

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_MOD   = 8'h25;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'd0,
        OP_PLUS  = 3'd1,
        OP_MINUS = 3'd2,
        OP_MUL   = 3'd3,
        OP_DIV   = 3'd4,
        OP_MOD   = 3'd5
    } op_code_t;

    typedef enum logic [2:0] {
        ST_CHAR      = 3'd0,
        ST_END       = 3'd1,
        ST_INVALID   = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_cmd_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
               (c == CH_DIV) || (c == CH_MOD);
    endfunction

    function automatic op_code_t code_of(input logic [7:0] c);
        op_code_t r;
        unique case (c)
            CH_PLUS:  r = OP_PLUS;
            CH_MINUS: r = OP_MINUS;
            CH_MUL:   r = OP_MUL;
            CH_DIV:   r = OP_DIV;
            CH_MOD:   r = OP_MOD;
            default:  r = OP_OPEN;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] char_of(input op_code_t c);
        logic [7:0] r;
        unique case (c)
            OP_OPEN:  r = CH_OPEN;
            OP_PLUS:  r = CH_PLUS;
            OP_MINUS: r = CH_MINUS;
            OP_MUL:   r = CH_MUL;
            OP_DIV:   r = CH_DIV;
            OP_MOD:   r = CH_MOD;
            default:  r = CH_NONE;
        endcase
        return r;
    endfunction

    // multiplicative operators bind tighter
    function automatic logic rank_of(input op_code_t c);
        return (c == OP_MUL) || (c == OP_DIV) || (c == OP_MOD);
    endfunction

endpackage

`default_nettype wire

### sv/i2p_cell.sv
// One stack cell: holds an operator code, shifts down on push and up on pop.
`default_nettype none

module i2p_cell (
    input  wire                 clk,
    input  i2p_pkg::stack_cmd_t cmd,
    input  i2p_pkg::op_code_t   from_up,
    input  i2p_pkg::op_code_t   from_down,
    output i2p_pkg::op_code_t   code
);

    i2p_pkg::op_code_t code_reg;
    i2p_pkg::op_code_t code_next;

    always_comb
    begin
        code_next = code_reg;
        if (cmd.push)
        begin
            code_next = from_up;
        end
        else if (cmd.pop)
        begin
            code_next = from_down;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign code = code_reg;

endmodule

`default_nettype wire

### sv/i2p_stack.sv
// Operator stack built as a row of shifting cells; cell 0 is the top.
`default_nettype none

module i2p_stack (
    input  wire                 clk,
    input  i2p_pkg::stack_cmd_t cmd,
    input  i2p_pkg::op_code_t   push_code,
    output i2p_pkg::op_code_t   top_code,
    output i2p_pkg::op_code_t   second_code
);

    i2p_pkg::op_code_t codes [i2p_pkg::STACK_DEPTH];

    genvar i;
    generate
        for (i = 0; i < i2p_pkg::STACK_DEPTH; i++)
        begin : g_cell
            i2p_pkg::op_code_t up_code;
            i2p_pkg::op_code_t down_code;

            if (i == 0)
            begin : g_head
                assign up_code = push_code;
            end
            else
            begin : g_body
                assign up_code = codes[i-1];
            end

            if (i == i2p_pkg::STACK_DEPTH - 1)
            begin : g_tail
                assign down_code = i2p_pkg::OP_OPEN;
            end
            else
            begin : g_link
                assign down_code = codes[i+1];
            end

            i2p_cell u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .from_up   (up_code),
                .from_down (down_code),
                .code      (codes[i])
            );
        end
    endgenerate

    assign top_code    = codes[0];
    assign second_code = codes[1];

endmodule

`default_nettype wire

### sv/infix_to_postfix_converter.sv
// Top level: shunting-yard sequencer driving a shift-cell operator stack.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | in_valid in_stall kind symbol   | in
//   output  | out_valid out_stall out_char    | out
//           | status last                     |
//
// A transfer is taken in S_IDLE; S_RUN then works through results and stack pops
// while the output slot is free, then returns to S_IDLE.
// End pops every stacked entry, then reports unmatched if an open paren was left.
// Reset clears the sequencer, stack count and output register.
// A stalled pending output freezes the sequencer; input is stalled while an item is in work.
`default_nettype none

module infix_to_postfix_converter (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire        kind,
    input  wire  [7:0] symbol,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] out_char,
    output logic [2:0] status,
    output logic       last
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                        state_reg, state_next;
    logic                          kind_reg, kind_next;
    logic [7:0]                    sym_reg, sym_next;
    logic                          open_left_reg, open_left_next;
    logic [i2p_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          out_valid_reg, out_valid_next;
    logic [7:0]                    out_char_reg, out_char_next;
    i2p_pkg::status_t              status_reg, status_next;
    logic                          last_reg, last_next;

    i2p_pkg::stack_cmd_t           cmd;
    i2p_pkg::op_code_t             push_code;
    i2p_pkg::op_code_t             top_code;
    i2p_pkg::op_code_t             second_code;
    i2p_pkg::op_code_t             in_code;

    logic                          slot_free;
    logic                          not_empty;
    logic                          full;
    logic                          emit;
    logic [7:0]                    emit_char;
    i2p_pkg::status_t              emit_status;
    logic                          emit_last;

    i2p_stack u_stack (
        .clk         (clk),
        .cmd         (cmd),
        .push_code   (push_code),
        .top_code    (top_code),
        .second_code (second_code)
    );

    assign slot_free = !out_valid_reg || !out_stall;
    assign not_empty = count_reg != '0;
    assign full      = count_reg == i2p_pkg::COUNT_FULL;
    assign in_code   = i2p_pkg::code_of(sym_reg);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        sym_next       = sym_reg;
        open_left_next = open_left_reg;
        count_next     = count_reg;
        cmd            = '0;
        push_code      = i2p_pkg::OP_OPEN;
        emit           = 1'b0;
        emit_char      = i2p_pkg::CH_NONE;
        emit_status    = i2p_pkg::ST_CHAR;
        emit_last      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    sym_next       = symbol;
                    open_left_next = 1'b0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                if (slot_free)
                begin
                    if (kind_reg)
                    begin
                        if (not_empty)
                        begin
                            cmd.pop    = 1'b1;
                            count_next = count_reg - i2p_pkg::COUNT_W'(1);
                            if (top_code == i2p_pkg::OP_OPEN)
                            begin
                                open_left_next = 1'b1;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_char = i2p_pkg::char_of(top_code);
                            end
                        end
                        else if (open_left_reg)
                        begin
                            open_left_next = 1'b0;
                            emit           = 1'b1;
                            emit_status    = i2p_pkg::ST_UNMATCHED;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_status = i2p_pkg::ST_END;
                            emit_last   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (i2p_pkg::is_alnum(sym_reg))
                    begin
                        emit       = 1'b1;
                        emit_char  = sym_reg;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (sym_reg == i2p_pkg::CH_OPEN)
                    begin
                        state_next = S_IDLE;
                        if (full)
                        begin
                            emit        = 1'b1;
                            emit_status = i2p_pkg::ST_OVERFLOW;
                            emit_last   = 1'b1;
                        end
                        else
                        begin
                            cmd.push   = 1'b1;
                            push_code  = i2p_pkg::OP_OPEN;
                            count_next = count_reg + i2p_pkg::COUNT_W'(1);
                        end
                    end
                    else if (sym_reg == i2p_pkg::CH_CLOSE)
                    begin
                        if (not_empty)
                        begin
                            cmd.pop    = 1'b1;
                            count_next = count_reg - i2p_pkg::COUNT_W'(1);
                            if (top_code == i2p_pkg::OP_OPEN)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                emit      = 1'b1;
                                emit_char = i2p_pkg::char_of(top_code);
                                emit_last = (count_reg != i2p_pkg::COUNT_W'(1)) &&
                                            (second_code == i2p_pkg::OP_OPEN);
                            end
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_status = i2p_pkg::ST_UNMATCHED;
                            emit_last   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    else if (i2p_pkg::is_op(sym_reg))
                    begin
                        if (not_empty && (top_code != i2p_pkg::OP_OPEN) &&
                            (i2p_pkg::rank_of(top_code) >= i2p_pkg::rank_of(in_code)))
                        begin
                            cmd.pop    = 1'b1;
                            count_next = count_reg - i2p_pkg::COUNT_W'(1);
                            emit       = 1'b1;
                            emit_char  = i2p_pkg::char_of(top_code);
                            // last pop when the next entry stops the scan; push follows silently
                            emit_last  = (count_reg == i2p_pkg::COUNT_W'(1)) ||
                                         (second_code == i2p_pkg::OP_OPEN) ||
                                         (i2p_pkg::rank_of(second_code) <
                                          i2p_pkg::rank_of(in_code));
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            if (full)
                            begin
                                emit        = 1'b1;
                                emit_status = i2p_pkg::ST_OVERFLOW;
                                emit_last   = 1'b1;
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                push_code  = in_code;
                                count_next = count_reg + i2p_pkg::COUNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = i2p_pkg::ST_INVALID;
                        emit_last   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            status_next    = emit_status;
            last_next      = emit_last;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
            out_char_next  = out_char_reg;
            status_next    = status_reg;
            last_next      = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= 1'b0;
            sym_reg       <= 8'h00;
            open_left_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= 8'h00;
            status_reg    <= i2p_pkg::ST_CHAR;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            sym_reg       <= sym_next;
            open_left_reg <= open_left_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

### sv/i2p_checker.sv
// Port-level checker for the infix to postfix converter, bound to the top level.
`default_nettype none

module i2p_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_stall,
    input wire       out_valid,
    input wire       out_stall,
    input wire [7:0] out_char,
    input wire [2:0] status,
    input wire       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(status) &&
        $stable(last))
        else $error("stalled output transfer changed");

    a_status_zero_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != i2p_pkg::ST_CHAR) |-> out_char == i2p_pkg::CH_NONE)
        else $error("status-only result carries a character");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((status == i2p_pkg::ST_END) || (status == i2p_pkg::ST_INVALID) ||
        (status == i2p_pkg::ST_OVERFLOW)) |-> last)
        else $error("terminal status not marked last");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .status    (status),
    .last      (last)
);

`default_nettype wire
